### rtl/core/bgd_pkg.sv
// Types and constants shared by the button gesture detector.
`default_nettype none
package bgd_pkg;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_PRESSED     = 5'b00010,
    PH_RELEASED    = 5'b00100,
    PH_WAIT_DOUBLE = 5'b01000,
    PH_LONG        = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SHORT    = 3'd1,
    EV_LONG     = 3'd2,
    EV_LONG_END = 3'd3,
    EV_DOUBLE   = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LONG_PRESS = 3'd1,
    REG_SHORT_MAX  = 3'd2,
    REG_DOUBLE_MAX = 3'd3,
    REG_HOLD_REP   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] short_press_max_ms;
    logic [15:0] double_click_max_ms;
    logic [15:0] hold_repeat_ms;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] press_start_time;
    logic [31:0] release_time;
    logic [31:0] hold_mark_time;
    logic [1:0]  click_count;
  } btn_state_t;

  localparam int unsigned STATE_W = $bits(btn_state_t);

  localparam btn_state_t STATE_RESET = '{
    phase:            PH_IDLE,
    press_start_time: 32'd0,
    release_time:     32'd0,
    hold_mark_time:   32'd0,
    click_count:      2'd0
  };

endpackage
`default_nettype wire

### rtl/core/bgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/bgd_cfg.sv
// Configuration register file for the gesture timing thresholds.
`default_nettype none
module bgd_cfg
  import bgd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms         <= 16'd20;
      cfg_r.long_press_ms       <= 16'd1000;
      cfg_r.short_press_max_ms  <= 16'd500;
      cfg_r.double_click_max_ms <= 16'd300;
      cfg_r.hold_repeat_ms      <= 16'd200;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg_r.debounce_ms         <= cfg_data;
        REG_LONG_PRESS: cfg_r.long_press_ms       <= cfg_data;
        REG_SHORT_MAX:  cfg_r.short_press_max_ms  <= cfg_data;
        REG_DOUBLE_MAX: cfg_r.double_click_max_ms <= cfg_data;
        REG_HOLD_REP:   cfg_r.hold_repeat_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/bgd_fsm.sv
// Per-button gesture state update: next state and event for one poll.
`default_nettype none
module bgd_fsm
  import bgd_pkg::*;
(
  input  wire btn_state_t   cur,
  input  wire cfg_t         cfg,
  input  wire logic         pressed,
  input  wire logic [31:0]  now_ms,
  output btn_state_t        nxt,
  output event_t            ev
);

  logic [31:0] d_press;
  logic [31:0] d_rel;
  logic [31:0] d_hold;
  logic [31:0] d_held;

  assign d_press = now_ms - cur.press_start_time;
  assign d_rel   = now_ms - cur.release_time;
  assign d_hold  = now_ms - cur.hold_mark_time;
  assign d_held  = cur.release_time - cur.press_start_time;

  always_comb begin
    nxt = cur;
    ev  = EV_NONE;
    case (cur.phase)
      PH_PRESSED: begin
        if (!pressed) begin
          if (d_press > {16'd0, cfg.debounce_ms}) begin
            nxt.release_time = now_ms;
            nxt.click_count  = cur.click_count + 2'd1;
            nxt.phase        = PH_RELEASED;
          end else begin
            nxt.phase = PH_IDLE;
          end
        end else if (d_press > {16'd0, cfg.long_press_ms}) begin
          nxt.phase          = PH_LONG;
          nxt.hold_mark_time = now_ms;
          ev                 = EV_LONG;
        end
      end
      PH_RELEASED: begin
        if (d_rel > {16'd0, cfg.debounce_ms}) begin
          if (cur.click_count == 2'd1) begin
            nxt.phase = PH_WAIT_DOUBLE;
          end else if (cur.click_count == 2'd2) begin
            nxt.phase       = PH_IDLE;
            nxt.click_count = 2'd0;
            ev              = EV_DOUBLE;
          end
        end
      end
      PH_WAIT_DOUBLE: begin
        if (pressed) begin
          nxt.press_start_time = now_ms;
          nxt.phase            = PH_PRESSED;
        end else if (d_rel > {16'd0, cfg.double_click_max_ms}) begin
          nxt.phase       = PH_IDLE;
          nxt.click_count = 2'd0;
          if (d_held < {16'd0, cfg.short_press_max_ms}) begin
            ev = EV_SHORT;
          end
        end
      end
      PH_LONG: begin
        if (d_hold > {16'd0, cfg.hold_repeat_ms}) begin
          nxt.hold_mark_time = now_ms;
          ev                 = EV_LONG;
        end
        if (!pressed) begin
          nxt.phase = PH_IDLE;
          ev        = EV_LONG_END;
        end
      end
      default: begin
        if (pressed) begin
          nxt.press_start_time = now_ms;
          nxt.phase            = PH_PRESSED;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/button_gesture_detector_unit.sv
// Top level of the button gesture detector: RAM-held state, read-modify-write pipe.
//
//  channel | dir | beat contents                               | handshake
//  in_     | in  | tdata[1:0] button_index, [2] pin_level,     | tvalid/tready
//          |     | [34:3] now_ms                               |
//  out_    | out | tdata[2:0] event_code                       | tvalid/tready
//  cfg_    | in  | index (3b), data (16b)                      | valid/ready
//
// One beat per cycle while the output is not stalled; each beat yields one result
// (state RAM read on acceptance, then update and write-back). Back-to-back polls of
// the same button are served from a forwarding register of the last write.
// Synchronous reset marks every button entry as reset state through valid
// flops; no clearing pass. A stalled output holds one result while one more
// beat waits in the update stage.
`default_nettype none
module button_gesture_detector_unit
  import bgd_pkg::*;
#(
  parameter int BUTTON_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [1:0] button_index, [2] pin_level, [34:3] now_ms
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [2:0] event_code
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  cfg_t cfg;

  logic [1:0]    in_idx;
  logic          in_pin;
  logic [31:0]   in_now;
  logic [AW-1:0] in_addr;
  logic          in_inr;
  logic          accept;

  logic          s1_valid_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_inr_r;
  logic          s1_pressed_r;
  logic [31:0]   s1_now_r;
  logic          s1_vld_r;
  logic          advance;

  logic [BUTTON_COUNT-1:0] vld_r;
  logic                    fwd_valid_r;
  logic [AW-1:0]           fwd_addr_r;
  btn_state_t              fwd_data_r;

  logic [STATE_W-1:0] ram_rdata;
  btn_state_t         cur_state;
  btn_state_t         nxt_state;
  event_t             ev;
  logic               we;

  logic   out_valid_r;
  event_t out_ev_r;

  assign in_idx  = in_tdata[1:0];
  assign in_pin  = in_tdata[2];
  assign in_now  = in_tdata[34:3];
  assign in_addr = AW'(in_idx);
  assign in_inr  = (32'(in_idx) < BUTTON_COUNT);

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;
  assign we        = advance && s1_inr_r;

  bgd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgd_ram #(
    .WIDTH (STATE_W),
    .DEPTH (BUTTON_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr_r),
    .wdata (nxt_state),
    .re    (accept && in_inr),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      cur_state = fwd_data_r;
    end else if (s1_vld_r) begin
      cur_state = btn_state_t'(ram_rdata);
    end else begin
      cur_state = STATE_RESET;
    end
  end

  bgd_fsm u_fsm (
    .cur     (cur_state),
    .cfg     (cfg),
    .pressed (!s1_pressed_r),
    .now_ms  (s1_now_r),
    .nxt     (nxt_state),
    .ev      (ev)
  );

  // s1_pressed_r carries the raw pin level; the FSM takes it inverted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r    <= in_addr;
      s1_inr_r     <= in_inr;
      s1_pressed_r <= in_pin;
      s1_now_r     <= in_now;
      s1_vld_r     <= in_inr && vld_r[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      fwd_valid_r <= 1'b0;
    end else if (we) begin
      vld_r[s1_addr_r] <= 1'b1;
      fwd_valid_r      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= nxt_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev_r <= s1_inr_r ? ev : EV_NONE;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_ev_r};

endmodule
`default_nettype wire

### verif/gesture_checker.sv
// Checker for the button gesture detector: predicts each poll's event and compares results.
module gesture_checker
  import bgd_pkg::*;
#(
  parameter int BUTTON_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output logic [4:0]  kinds_seen
);

  cfg_t        knobs;
  phase_t      btn_phase  [BUTTON_COUNT];
  logic [31:0] press_at   [BUTTON_COUNT];
  logic [31:0] release_at [BUTTON_COUNT];
  logic [31:0] repeat_at  [BUTTON_COUNT];
  logic [1:0]  clicks     [BUTTON_COUNT];
  event_t      expected_events[$];

  function automatic logic [31:0] since(input logic [31:0] later, input logic [31:0] earlier);
    return later - earlier;
  endfunction

  function automatic event_t next_event(input logic [1:0] b, input logic pin,
                                        input logic [31:0] now);
    event_t ev;
    logic   held;
    ev = EV_NONE;
    held = ~pin;
    if (int'(b) >= BUTTON_COUNT) return EV_NONE;
    case (btn_phase[b])
      PH_PRESSED: begin
        if (!held) begin
          if (since(now, press_at[b]) > {16'd0, knobs.debounce_ms}) begin
            release_at[b] = now;
            clicks[b] = clicks[b] + 2'd1;
            btn_phase[b] = PH_RELEASED;
          end else begin
            btn_phase[b] = PH_IDLE;
          end
        end else if (since(now, press_at[b]) > {16'd0, knobs.long_press_ms}) begin
          btn_phase[b] = PH_LONG;
          ev = EV_LONG;
          repeat_at[b] = now;
        end
      end
      PH_RELEASED: begin
        // counts other than one or two leave the button parked here
        if (since(now, release_at[b]) > {16'd0, knobs.debounce_ms}) begin
          if (clicks[b] == 2'd1) begin
            btn_phase[b] = PH_WAIT_DOUBLE;
          end else if (clicks[b] == 2'd2) begin
            btn_phase[b] = PH_IDLE;
            clicks[b] = 2'd0;
            ev = EV_DOUBLE;
          end
        end
      end
      PH_WAIT_DOUBLE: begin
        if (held) begin
          press_at[b] = now;
          btn_phase[b] = PH_PRESSED;
        end else if (since(now, release_at[b]) > {16'd0, knobs.double_click_max_ms}) begin
          btn_phase[b] = PH_IDLE;
          clicks[b] = 2'd0;
          if (since(release_at[b], press_at[b]) < {16'd0, knobs.short_press_max_ms})
            ev = EV_SHORT;
        end
      end
      PH_LONG: begin
        if (since(now, repeat_at[b]) > {16'd0, knobs.hold_repeat_ms}) begin
          ev = EV_LONG;
          repeat_at[b] = now;
        end
        // release wins over a repeat due in the same poll
        if (!held) begin
          btn_phase[b] = PH_IDLE;
          ev = EV_LONG_END;
        end
      end
      default: begin
        if (held) begin
          press_at[b] = now;
          btn_phase[b] = PH_PRESSED;
        end
      end
    endcase
    return ev;
  endfunction

  always @(posedge clk) begin : watch
    event_t     want;
    logic [2:0] got;
    if (!rst_n) begin
      knobs = '{debounce_ms: 16'd20, long_press_ms: 16'd1000, short_press_max_ms: 16'd500,
                double_click_max_ms: 16'd300, hold_repeat_ms: 16'd200};
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        btn_phase[i] = PH_IDLE;
        press_at[i] = '0;
        release_at[i] = '0;
        repeat_at[i] = '0;
        clicks[i] = '0;
      end
      expected_events.delete();
      fail_count = 0;
      checked = 0;
      kinds_seen = '0;
    end else begin
      // results leave before new polls enter: a result never belongs to this edge's poll
      if (out_tvalid && out_tready) begin
        got = out_tdata[2:0];
        if (expected_events.size() == 0) begin
          $error("event_code: no poll outstanding, actual %0d", got);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          checked++;
          if (got !== want) begin
            $error("event_code mismatch: expected %0d, actual %0d", want, got);
            fail_count++;
          end else begin
            kinds_seen[want] = 1'b1;
          end
          if (out_tdata[7:3] !== 5'd0) begin
            $error("out_tdata pad mismatch: expected 0, actual %0d", out_tdata[7:3]);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_DEBOUNCE:   knobs.debounce_ms = cfg_data;
          REG_LONG_PRESS: knobs.long_press_ms = cfg_data;
          REG_SHORT_MAX:  knobs.short_press_max_ms = cfg_data;
          REG_DOUBLE_MAX: knobs.double_click_max_ms = cfg_data;
          REG_HOLD_REP:   knobs.hold_repeat_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_events.push_back(next_event(in_tdata[1:0], in_tdata[2], in_tdata[34:3]));
    end
    pending = expected_events.size();
  end

endmodule

### verif/tb.sv
// Testbench top for the button gesture detector: clock, reset, poll stimulus and verdict.
module tb;
  import bgd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [1:0] button_index, [2] pin_level, [34:3] now_ms
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [2:0] event_code
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending;
  int          checked;
  logic [4:0]  kinds_seen;

  cfg_t        knobs;
  logic [31:0] clock_ms;
  int          polls_sent;
  int          stall_pct;
  int          stall_left;
  int          cycles;
  bit          quiet;

  button_gesture_detector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gesture_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .kinds_seen (kinds_seen)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(1, 100) <= stall_pct) stall_left = gap_len();
    end
  end

  task automatic poll(input logic [1:0] b, input logic pin, input logic [31:0] t);
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, t, pin, b};
    do @(posedge clk); while (!in_tready);
    polls_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_knobs(input logic [15:0] d, input logic [15:0] l, input logic [15:0] s,
                           input logic [15:0] w, input logic [15:0] r);
    knobs = '{debounce_ms: d, long_press_ms: l, short_press_max_ms: s,
              double_click_max_ms: w, hold_repeat_ms: r};
    cfg_write(REG_DEBOUNCE, d);
    cfg_write(REG_LONG_PRESS, l);
    cfg_write(REG_SHORT_MAX, s);
    cfg_write(REG_DOUBLE_MAX, w);
    cfg_write(REG_HOLD_REP, r);
  endtask

  // time step that lands on, just around, or well away from a threshold
  function automatic logic [31:0] pick_dt(input logic [15:0] th);
    logic [31:0] w;
    w = {16'd0, th};
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return w;
      2: return w + 32'd1;
      3: return (th == 16'd0) ? 32'd0 : w - 32'd1;
      4: return $urandom_range(0, 2 * w + 2);
      default: return $urandom_range(w / 2, w + w / 2 + 1);
    endcase
  endfunction

  task automatic hold(input logic [1:0] b, input logic pin, input int steps,
                      input logic [15:0] th);
    logic [1:0] other;
    repeat (steps) begin
      clock_ms += pick_dt(th);
      poll(b, pin, clock_ms);
      if ($urandom_range(0, 9) == 0) begin
        other = b + 2'($urandom_range(1, 3));
        poll(other, 1'($urandom_range(0, 1)), clock_ms);
      end
    end
  endtask

  task automatic run_gesture(input logic [1:0] b);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        hold(b, 1'b0, $urandom_range(1, 3),
             $urandom_range(0, 1) ? knobs.debounce_ms : knobs.short_press_max_ms);
        hold(b, 1'b1, $urandom_range(1, 2), knobs.debounce_ms);
        hold(b, 1'b1, $urandom_range(1, 3), knobs.double_click_max_ms);
      end
      4, 5, 6: begin
        hold(b, 1'b0, $urandom_range(1, 2), knobs.debounce_ms);
        hold(b, 1'b1, 1, knobs.debounce_ms);
        hold(b, 1'b1, 1, knobs.debounce_ms);
        hold(b, 1'b0, $urandom_range(1, 2), knobs.debounce_ms);
        hold(b, 1'b1, $urandom_range(1, 2), knobs.debounce_ms);
        hold(b, 1'b1, $urandom_range(1, 2), knobs.debounce_ms);
      end
      7, 8: begin
        hold(b, 1'b0, 1, knobs.debounce_ms);
        hold(b, 1'b0, $urandom_range(1, 2), knobs.long_press_ms);
        hold(b, 1'b0, $urandom_range(1, 4), knobs.hold_repeat_ms);
        hold(b, 1'b1, 1, knobs.hold_repeat_ms);
      end
      default: begin
        hold(b, 1'b0, 1, knobs.debounce_ms);
        hold(b, 1'b1, 1, knobs.debounce_ms);
        hold(b, 1'b1, $urandom_range(1, 2), knobs.double_click_max_ms);
      end
    endcase
  endtask

  task automatic random_round();
    int         r;
    logic [1:0] b;
    r = $urandom_range(0, 99);
    if (r < 8) clock_ms = $urandom();
    else if (r < 12) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    quiet = ($urandom_range(0, 6) == 0);
    stall_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
    b = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0)
      poll(b, 1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0) ? $urandom() : clock_ms);
    else
      run_gesture(b);
  endtask

  initial begin : stimulus
    int start;
    bit paused;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    knobs = '{debounce_ms: 16'd20, long_press_ms: 16'd1000, short_press_max_ms: 16'd500,
              double_click_max_ms: 16'd300, hold_repeat_ms: 16'd200};
    clock_ms = 32'd1000;
    polls_sent = 0;
    stall_pct = 20;
    stall_left = 0;
    cycles = 0;
    quiet = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // time extremes on idle buttons
    poll(2'd0, 1'b1, 32'h0000_0000);
    poll(2'd1, 1'b1, 32'hFFFF_FFFF);
    // short press times out waiting for a second click
    poll(2'd0, 1'b0, 32'd1000);
    poll(2'd0, 1'b1, 32'd1030);
    poll(2'd0, 1'b1, 32'd1060);
    poll(2'd0, 1'b1, 32'd1400);
    // double click
    poll(2'd1, 1'b0, 32'd2000);
    poll(2'd1, 1'b1, 32'd2050);
    poll(2'd1, 1'b1, 32'd2080);
    poll(2'd1, 1'b0, 32'd2100);
    poll(2'd1, 1'b1, 32'd2150);
    poll(2'd1, 1'b1, 32'd2180);
    // long press across the time wrap, one repeat, then release with a repeat due
    poll(2'd2, 1'b0, 32'hFFFF_FE00);
    poll(2'd2, 1'b0, 32'hFFFF_FE00 + 32'd1001);
    poll(2'd2, 1'b0, 32'hFFFF_FE00 + 32'd1202);
    poll(2'd2, 1'b1, 32'hFFFF_FE00 + 32'd1403);
    // bounce, then a bounced second click keeps the count so a later click doubles
    poll(2'd3, 1'b0, 32'd5000);
    poll(2'd3, 1'b1, 32'd5010);
    poll(2'd3, 1'b0, 32'd6000);
    poll(2'd3, 1'b1, 32'd6030);
    poll(2'd3, 1'b1, 32'd6060);
    poll(2'd3, 1'b0, 32'd6100);
    poll(2'd3, 1'b1, 32'd6105);
    poll(2'd3, 1'b0, 32'd7000);
    poll(2'd3, 1'b1, 32'd7050);
    poll(2'd3, 1'b1, 32'd7080);
    clock_ms = 32'd8000;

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_drained();
        case (p)
          1: set_knobs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
          2: set_knobs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          3: set_knobs(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                       16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                       16'($urandom_range(0, 40)));
          4: set_knobs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
          default: set_knobs(16'($urandom_range(0, 30)), 16'($urandom_range(100, 2000)),
                             16'($urandom_range(50, 1000)), 16'($urandom_range(50, 600)),
                             16'($urandom_range(10, 300)));
        endcase
      end
      start = polls_sent;
      paused = 1'b0;
      while (polls_sent - start < 135) begin
        // hold off the sender until every result is back
        if (!paused && polls_sent - start >= 60) begin
          wait_drained();
          paused = 1'b1;
        end
        random_round();
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("covered %0d polls over defaults, all-zero, all-max and three random settings",
             polls_sent);
    $display("%0d results checked, event codes seen (bit n = code n): %b", checked, kinds_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bgd_pkg.sv
rtl/core/bgd_ram.sv
rtl/core/bgd_cfg.sv
rtl/core/bgd_fsm.sv
rtl/core/button_gesture_detector_unit.sv
verif/gesture_checker.sv
verif/tb.sv
